// ===== src/load_based_core_hotplug_policy_top_macros.svh =====
// Assertion macros for the hotplug policy modules; lbhp_emit includes them.
`ifndef LOAD_BASED_CORE_HOTPLUG_POLICY_TOP_MACROS_SVH
`define LOAD_BASED_CORE_HOTPLUG_POLICY_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define LBHP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define LBHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lbhp_pkg.sv =====
package lbhp_pkg;

  localparam int MAX_CORES     = 8;
  localparam int NUM_CORES_DEF = 8;
  localparam int RATE_W        = 22;
  localparam int CORE_W        = 3;
  localparam int CNT_W         = 4;
  localparam int PCT_W         = 7;
  localparam int HOLD_W        = 3;
  localparam int PROD_W        = RATE_W + PCT_W;
  localparam int SCALED_W      = RATE_W + 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 7;
  localparam logic [HOLD_W-1:0] HOLD_MAX = 3'd7;

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_SUSPEND = 2'd1,
    FUNC_RESUME  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_ONLINE  = 2'd1,
    ACT_OFFLINE = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED      = 3'd0,
    CFG_SCREEN_OFF   = 3'd1,
    CFG_MOST_CORES   = 3'd2,
    CFG_FEWEST_CORES = 3'd3,
    CFG_UP_PERCENT   = 3'd4,
    CFG_DOWN_PERCENT = 3'd5,
    CFG_UP_HOLD      = 3'd6,
    CFG_DOWN_HOLD    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              enabled;
    logic              screen_off_single;
    logic [CNT_W-1:0]  most_cores;
    logic [CNT_W-1:0]  fewest_cores;
    logic [PCT_W-1:0]  up_percent;
    logic [PCT_W-1:0]  down_percent;
    logic [HOLD_W-1:0] up_hold;
    logic [HOLD_W-1:0] down_hold;
  } cfg_t;

  typedef struct packed {
    func_t                               func;
    logic                                func_known;
    logic [MAX_CORES-1:0]                mask;
    logic [PROD_W-1:0]                   up_prod;
    logic [PROD_W-1:0]                   down_prod;
    logic [MAX_CORES-1:0][RATE_W-1:0]    rate;
  } item_t;

  typedef struct packed {
    action_t              action;
    logic [MAX_CORES-1:0] cores;
  } plan_t;

endpackage

// ===== src/lbhp_in_if.sv =====
interface lbhp_in_if
  import lbhp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [7:0]        online_mask;
  logic [RATE_W-1:0] max_freq;
  logic [RATE_W-1:0] freq_core0;
  logic [RATE_W-1:0] freq_core1;
  logic [RATE_W-1:0] freq_core2;
  logic [RATE_W-1:0] freq_core3;
  logic [RATE_W-1:0] freq_core4;
  logic [RATE_W-1:0] freq_core5;
  logic [RATE_W-1:0] freq_core6;
  logic [RATE_W-1:0] freq_core7;

  modport source (
    output valid, func, online_mask, max_freq, freq_core0, freq_core1, freq_core2,
           freq_core3, freq_core4, freq_core5, freq_core6, freq_core7,
    input  ready
  );
  modport sink (
    input  valid, func, online_mask, max_freq, freq_core0, freq_core1, freq_core2,
           freq_core3, freq_core4, freq_core5, freq_core6, freq_core7,
    output ready
  );
endinterface

// ===== src/lbhp_out_if.sv =====
interface lbhp_out_if
  import lbhp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [CORE_W-1:0] core;
  logic              last;

  modport source (output valid, action, core, last, input ready);
  modport sink   (input valid, action, core, last, output ready);
endinterface

// ===== src/lbhp_in_stage.sv =====
module lbhp_in_stage
  import lbhp_pkg::*;
#(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  lbhp_in_if.sink    in_ch,
  input  logic       load,
  output logic       item_vld,
  output item_t      item
);

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  item_t item_nxt;
  logic  accept;

  assign in_ch.ready = !vld_r || load;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (load) begin
      vld_nxt = 1'b0;
    end
  end

  always_comb begin
    item_nxt            = item_r;
    item_nxt.func       = func_t'(in_ch.func);
    item_nxt.func_known = (in_ch.func != 2'd3);
    item_nxt.mask       = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      item_nxt.mask[i] = (i == 0) ? 1'b1 : in_ch.online_mask[i];
    end
    item_nxt.up_prod   = PROD_W'(cfg.up_percent) * PROD_W'(in_ch.max_freq);
    item_nxt.down_prod = PROD_W'(cfg.down_percent) * PROD_W'(in_ch.max_freq);
    item_nxt.rate[0]   = in_ch.freq_core0;
    item_nxt.rate[1]   = in_ch.freq_core1;
    item_nxt.rate[2]   = in_ch.freq_core2;
    item_nxt.rate[3]   = in_ch.freq_core3;
    item_nxt.rate[4]   = in_ch.freq_core4;
    item_nxt.rate[5]   = in_ch.freq_core5;
    item_nxt.rate[6]   = in_ch.freq_core6;
    item_nxt.rate[7]   = in_ch.freq_core7;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

// ===== src/lbhp_decide.sv =====
module lbhp_decide
  import lbhp_pkg::*;
#(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  item_t item,
  input  logic  load,
  output plan_t plan
);

  logic [HOLD_W-1:0]    hold_r;
  logic [HOLD_W-1:0]    hold_nxt;
  logic                 suspended_r;
  logic                 suspended_nxt;
  logic [HOLD_W-1:0]    hold_inc;
  logic [CNT_W-1:0]     num;
  logic [CNT_W-1:0]     rcnt;
  logic                 have_slow;
  logic [RATE_W-1:0]    slow;
  logic [RATE_W-1:0]    fast;
  logic [CORE_W-1:0]    slow_core;
  logic                 have_off;
  logic [CORE_W-1:0]    off_core;
  logic                 slow_hi;
  logic                 fast_lo;
  logic [MAX_CORES-1:0] sel;
  action_t              act;

  function automatic logic [SCALED_W-1:0] times100(input logic [RATE_W:0] x);
    logic [SCALED_W-1:0] w;
    w = SCALED_W'(x);
    return (w << 6) + (w << 5) + (w << 2);
  endfunction

  always_comb begin
    hold_inc = (hold_r < HOLD_MAX) ? hold_r + 1'b1 : hold_r;

    num = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      num = num + CNT_W'(item.mask[i]);
    end

    have_slow = 1'b0;
    slow      = '0;
    slow_core = '0;
    fast      = item.rate[0];
    for (int i = 1; i < NUM_CORES; i++) begin
      if (item.mask[i]) begin
        if (!have_slow || item.rate[i] <= slow) begin
          have_slow = 1'b1;
          slow      = item.rate[i];
          slow_core = CORE_W'(i);
        end else if (item.rate[i] > fast) begin
          fast = item.rate[i];
        end
      end
    end
    if (!have_slow || item.rate[0] < slow) begin
      slow = item.rate[0];
    end

    // Thresholds compared as 100 * rate against percent * max_freq.
    slow_hi = times100({1'b0, slow}) > SCALED_W'(item.up_prod);
    fast_lo = times100({1'b0, fast} + 1'b1) <= SCALED_W'(item.down_prod);

    have_off = 1'b0;
    off_core = '0;
    for (int i = NUM_CORES - 1; i >= 1; i--) begin
      if (!item.mask[i]) begin
        have_off = 1'b1;
        off_core = CORE_W'(i);
      end
    end

    rcnt = num;
    sel  = '0;
    act  = ACT_NONE;
    hold_nxt      = hold_r;
    suspended_nxt = suspended_r;

    if (cfg.enabled && item.func_known) begin
      unique case (item.func)
        FUNC_TICK: begin
          if (!suspended_r) begin
            hold_nxt = hold_inc;
            if (slow_hi) begin
              if (num < cfg.most_cores && hold_inc >= cfg.up_hold && have_off) begin
                act           = ACT_ONLINE;
                sel[off_core] = 1'b1;
                hold_nxt      = '0;
              end
            end else if (have_slow && fast_lo) begin
              if (num > cfg.fewest_cores && hold_inc >= cfg.down_hold) begin
                act            = ACT_OFFLINE;
                sel[slow_core] = 1'b1;
                hold_nxt       = '0;
              end
            end
          end
        end
        FUNC_SUSPEND: begin
          suspended_nxt = 1'b1;
          if (cfg.screen_off_single) begin
            act = ACT_OFFLINE;
            sel = item.mask & ~MAX_CORES'(1);
          end
        end
        FUNC_RESUME: begin
          suspended_nxt = 1'b0;
          if (cfg.screen_off_single) begin
            act = ACT_ONLINE;
            for (int i = 0; i < NUM_CORES; i++) begin
              if (rcnt < cfg.most_cores && !item.mask[i]) begin
                sel[i] = 1'b1;
                rcnt   = rcnt + 1'b1;
              end
            end
          end
        end
        default: begin
          act = ACT_NONE;
        end
      endcase
    end

    if (sel == '0) begin
      plan.action = ACT_NONE;
      plan.cores  = MAX_CORES'(1);
    end else begin
      plan.action = act;
      plan.cores  = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r      <= '0;
      suspended_r <= 1'b0;
    end else if (load) begin
      hold_r      <= hold_nxt;
      suspended_r <= suspended_nxt;
    end
  end

endmodule

// ===== src/lbhp_emit.sv =====
`include "load_based_core_hotplug_policy_top_macros.svh"

module lbhp_emit
  import lbhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       plan_vld,
  input  plan_t      plan,
  lbhp_out_if.source out_ch,
  output logic       load
);

  logic                 vld_r;
  logic                 vld_nxt;
  action_t              act_r;
  action_t              act_nxt;
  logic [MAX_CORES-1:0] cores_r;
  logic [MAX_CORES-1:0] cores_nxt;
  logic                 last;
  logic                 free;
  logic [CORE_W-1:0]    core;

  assign last = (cores_r & (cores_r - 1'b1)) == '0;
  assign free = !vld_r || (out_ch.ready && last);
  assign load = plan_vld && free;

  always_comb begin
    core = '0;
    for (int i = MAX_CORES - 1; i >= 0; i--) begin
      if (cores_r[i]) begin
        core = CORE_W'(i);
      end
    end
  end

  always_comb begin
    vld_nxt   = vld_r;
    act_nxt   = act_r;
    cores_nxt = cores_r;
    if (load) begin
      vld_nxt   = 1'b1;
      act_nxt   = plan.action;
      cores_nxt = plan.cores;
    end else if (vld_r && out_ch.ready) begin
      if (last) begin
        vld_nxt = 1'b0;
      end else begin
        cores_nxt = cores_r & (cores_r - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    cores_r <= cores_nxt;
  end

  assign out_ch.valid  = vld_r;
  assign out_ch.action = act_r;
  assign out_ch.core   = core;
  assign out_ch.last   = last;

  `LBHP_ASSERT(a_vld_has_core, vld_r, cores_r != '0, "Result register holds no core.")
  `LBHP_ASSERT(a_none_is_last, vld_r && act_r == ACT_NONE, last, "No-action result not last.")
  `LBHP_ASSERT_NXT(a_more_follow, vld_r && out_ch.ready && !last, vld_r && $countones(cores_r) == $countones($past(cores_r)) - 1, "Pending results of an item were lost.")
  `LBHP_ASSERT_NXT(a_load_shows, load, vld_r && cores_r == $past(plan.cores), "Loaded plan not presented.")

endmodule

// ===== src/load_based_core_hotplug_policy_top.sv =====
// Core hotplug policy. Each input item (a sampling tick, a suspend or a resume
// event) yields one or more results on the output channel, the final one
// flagged by last; an item that changes nothing yields a single no-action
// result for core 0. An item passes through an input register, where the two
// threshold products are formed, and then through the decision logic into the
// result register, from which its results are offered on the output channel.
// An item giving one result frees the result register when it is taken, and a
// new item can be accepted in every cycle while the output is ready; an item
// giving several results (up to seven on suspend or resume) holds the result
// register until its last one is taken. There is no clearing pass after reset.
// The user must write configuration registers through cfg_we, cfg_index and
// cfg_data only while no item is in flight; the block does not enforce this.
module load_based_core_hotplug_policy_top
  import lbhp_pkg::*;
#(
  parameter int NUM_CORES = NUM_CORES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lbhp_in_if.sink               in_ch,
  lbhp_out_if.source            out_ch
);

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  item_vld;
  item_t item;
  plan_t plan;
  logic  load;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ENABLED:      cfg_nxt.enabled           = cfg_data[0];
        CFG_SCREEN_OFF:   cfg_nxt.screen_off_single = cfg_data[0];
        CFG_MOST_CORES:   cfg_nxt.most_cores        = cfg_data[CNT_W-1:0];
        CFG_FEWEST_CORES: cfg_nxt.fewest_cores      = cfg_data[CNT_W-1:0];
        CFG_UP_PERCENT:   cfg_nxt.up_percent        = cfg_data[PCT_W-1:0];
        CFG_DOWN_PERCENT: cfg_nxt.down_percent      = cfg_data[PCT_W-1:0];
        CFG_UP_HOLD:      cfg_nxt.up_hold           = cfg_data[HOLD_W-1:0];
        CFG_DOWN_HOLD:    cfg_nxt.down_hold         = cfg_data[HOLD_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled           <= 1'b0;
      cfg_r.screen_off_single <= 1'b1;
      cfg_r.most_cores        <= CNT_W'(8);
      cfg_r.fewest_cores      <= CNT_W'(2);
      cfg_r.up_percent        <= PCT_W'(60);
      cfg_r.down_percent      <= PCT_W'(40);
      cfg_r.up_hold           <= HOLD_W'(2);
      cfg_r.down_hold         <= HOLD_W'(2);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lbhp_in_stage #(
    .NUM_CORES (NUM_CORES)
  ) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .load     (load),
    .item_vld (item_vld),
    .item     (item)
  );

  lbhp_decide #(
    .NUM_CORES (NUM_CORES)
  ) u_decide (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (item),
    .load  (load),
    .plan  (plan)
  );

  lbhp_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .plan_vld (item_vld),
    .plan     (plan),
    .out_ch   (out_ch),
    .load     (load)
  );

endmodule
